>>> src/tcpf_pkg.sv
`timescale 1ns / 1ps

package tcpf_pkg;

   localparam int LIMIT_W          = 5;
   localparam int MODE_W           = 2;
   localparam int STATUS_W         = 2;
   localparam int DEF_MAX_DEPTH    = 16;
   localparam int DEF_PAYLOAD_BITS = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT      = 2'd0,
      MODE_PRIO_PUT = 2'd1,
      MODE_GET      = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } store_cmd_type;

endpackage

>>> src/two_class_priority_fifo_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_mode, req_payload
// rsp       out        rsp_valid / rsp_ready   rsp_status, rsp_read_payload,
//                                              rsp_read_was_priority,
//                                              rsp_occupancy, rsp_priority_count
// csr       in         csr_valid / csr_ready   csr_queue_limit
//
// One transaction per cycle is sustained while rsp_ready stays high; a result is held in
// the result register once its request has passed through the input register.
// The queue shifts all entries in parallel.
// Reset empties the queue and sets the limit to 5; csr_ready is always high.
// A stalled result holds the input register, which still accepts while empty.

module two_class_priority_fifo_unit #(
   parameter int MAX_DEPTH    = tcpf_pkg::DEF_MAX_DEPTH,
   parameter int PAYLOAD_BITS = tcpf_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcpf_pkg::MODE_W-1:0]         req_mode,
   input  logic [PAYLOAD_BITS-1:0]             req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tcpf_pkg::STATUS_W-1:0]       rsp_status,
   output logic [PAYLOAD_BITS-1:0]             rsp_read_payload,
   output logic                                rsp_read_was_priority,
   output logic [$clog2(MAX_DEPTH+1)-1:0]      rsp_occupancy,
   output logic [$clog2(MAX_DEPTH+1)-1:0]      rsp_priority_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcpf_pkg::LIMIT_W-1:0]        csr_queue_limit
);
   import tcpf_pkg::*;

   localparam int COUNT_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W   = $clog2(MAX_DEPTH);
   localparam int LIM_W   = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

   logic                    s1_valid_ff, s1_valid_in;
   logic [MODE_W-1:0]       s1_mode_ff;
   logic [PAYLOAD_BITS-1:0] s1_payload_ff;

   logic [LIMIT_W-1:0]      limit_ff;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      prio_ff, prio_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic [PAYLOAD_BITS-1:0] read_payload_ff, read_payload_in;
   logic                    read_prio_ff, read_prio_in;

   logic                    advance;
   logic [LIM_W-1:0]        eff_limit;
   logic                    is_full;
   logic                    is_empty;
   store_cmd_type           store_cmd;
   logic [IDX_W-1:0]        store_pos;
   logic [PAYLOAD_BITS-1:0] store_head;

   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_mode_ff    <= req_mode;
         s1_payload_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_queue_limit;
      end
   end

   // A limit of zero acts as one, and a limit above the depth as the depth.
   always_comb begin
      eff_limit = LIM_W'(limit_ff);
      if (eff_limit == '0) begin
         eff_limit = LIM_W'(1);
      end
      if (eff_limit > LIM_W'(MAX_DEPTH)) begin
         eff_limit = LIM_W'(MAX_DEPTH);
      end
   end

   assign is_full  = LIM_W'(count_ff) >= eff_limit;
   assign is_empty = (count_ff == '0);

   always_comb begin
      store_cmd       = '0;
      store_pos       = count_ff[IDX_W-1:0];
      count_in        = count_ff;
      prio_in         = prio_ff;
      status_in       = STATUS_DONE;
      read_payload_in = '0;
      read_prio_in    = 1'b0;
      if (advance) begin
         unique case (s1_mode_ff)
            MODE_PUT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  store_cmd.push = 1'b1;
                  count_in       = count_ff + COUNT_W'(1);
               end
            end
            MODE_PRIO_PUT: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  store_cmd.push = 1'b1;
                  store_pos      = prio_ff[IDX_W-1:0];
                  count_in       = count_ff + COUNT_W'(1);
                  prio_in        = prio_ff + COUNT_W'(1);
               end
            end
            MODE_GET: begin
               if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  store_cmd.pop   = 1'b1;
                  read_payload_in = store_head;
                  read_prio_in    = (prio_ff != '0);
                  count_in        = count_ff - COUNT_W'(1);
                  if (prio_ff != '0) begin
                     prio_in = prio_ff - COUNT_W'(1);
                  end
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   tcpf_store #(
      .DEPTH (MAX_DEPTH),
      .WIDTH (PAYLOAD_BITS)
   ) u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .pos     (store_pos),
      .wr_data (s1_payload_ff),
      .head    (store_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prio_ff  <= '0;
      end else begin
         count_ff <= count_in;
         prio_ff  <= prio_in;
      end
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff       <= status_in;
         read_payload_ff <= read_payload_in;
         read_prio_ff    <= read_prio_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_read_payload      = read_payload_ff;
   assign rsp_read_was_priority = read_prio_ff;
   assign rsp_occupancy         = count_ff;
   assign rsp_priority_count    = prio_ff;

   // The priority region always lies inside the occupied part of the queue.
   a_prio_within_count: assert property (@(posedge clock) disable iff (reset)
      prio_ff <= count_ff)
      else $error("priority count exceeds occupancy");

   a_count_within_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_DEPTH))
      else $error("occupancy exceeds depth");

   // A rejected transaction leaves both counts untouched.
   a_reject_keeps_counts: assert property (@(posedge clock) disable iff (reset)
      advance && (status_in != STATUS_DONE) |=> $stable(count_ff) && $stable(prio_ff))
      else $error("rejected transaction changed the counts");

   // A successful get removes exactly one entry.
   a_get_pops_one: assert property (@(posedge clock) disable iff (reset)
      advance && store_cmd.pop |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("get did not remove exactly one entry");

endmodule

>>> src/tcpf_store.sv
`timescale 1ns / 1ps

module tcpf_store #(
   parameter int DEPTH = tcpf_pkg::DEF_MAX_DEPTH,
   parameter int WIDTH = tcpf_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                         clock,
   input  tcpf_pkg::store_cmd_type      cmd,
   input  logic [$clog2(DEPTH)-1:0]     pos,
   input  logic [WIDTH-1:0]             wr_data,
   output logic [WIDTH-1:0]             head
);
   import tcpf_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] entry_in [DEPTH];

   // Every entry looks only at its two neighbors and the write word, so an
   // insert or a pop shifts all entries of the queue in parallel.
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      always_comb begin
         entry_in[i] = entry_ff[i];
         if (cmd.push) begin
            if (IDX_W'(i) == pos) begin
               entry_in[i] = wr_data;
            end else if (IDX_W'(i) > pos) begin
               if (i > 0) begin
                  entry_in[i] = entry_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else if (cmd.pop) begin
            if (i < DEPTH - 1) begin
               entry_in[i] = entry_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   assign head = entry_ff[0];

endmodule

>>> tb/queue_result_checker.sv
`timescale 1ns / 1ps

module queue_result_checker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_ready,
   input  logic [tcpf_pkg::MODE_W-1:0]                  req_mode,
   input  logic [tcpf_pkg::DEF_PAYLOAD_BITS-1:0]        req_payload,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   input  logic [tcpf_pkg::STATUS_W-1:0]                rsp_status,
   input  logic [tcpf_pkg::DEF_PAYLOAD_BITS-1:0]        rsp_read_payload,
   input  logic                                         rsp_read_was_priority,
   input  logic [$clog2(tcpf_pkg::DEF_MAX_DEPTH+1)-1:0] rsp_occupancy,
   input  logic [$clog2(tcpf_pkg::DEF_MAX_DEPTH+1)-1:0] rsp_priority_count,
   input  logic                                         csr_valid,
   input  logic                                         csr_ready,
   input  logic [tcpf_pkg::LIMIT_W-1:0]                 csr_queue_limit,
   output int                                           mismatch_count,
   output int                                           results_outstanding
);
   import tcpf_pkg::*;

   localparam int COUNT_W = $clog2(DEF_MAX_DEPTH + 1);

   typedef struct {
      status_type                  status;
      logic [DEF_PAYLOAD_BITS-1:0] read_payload;
      logic                        read_was_priority;
      logic [COUNT_W-1:0]          occupancy;
      logic [COUNT_W-1:0]          priority_count;
   } queue_result_type;

   logic [DEF_PAYLOAD_BITS-1:0] shadow_entries[$];
   int                          shadow_priority;
   logic [LIMIT_W-1:0]          shadow_limit = LIMIT_RESET;
   queue_result_type            expected_results[$];

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic queue_result_type apply_queue_op(input logic [MODE_W-1:0] op,
                                                       input logic [DEF_PAYLOAD_BITS-1:0] word);
      queue_result_type r;
      int               cap;
      r.status            = STATUS_DONE;
      r.read_payload      = '0;
      r.read_was_priority = 1'b0;
      cap = int'(shadow_limit);
      if (cap == 0) begin
         cap = 1;
      end
      if (cap > DEF_MAX_DEPTH) begin
         cap = DEF_MAX_DEPTH;
      end
      case (op)
         MODE_PUT, MODE_PRIO_PUT: begin
            if (shadow_entries.size() >= cap) begin
               r.status = STATUS_FULL;
            end else if (op == MODE_PUT) begin
               shadow_entries.insert(shadow_entries.size(), word);
            end else begin
               if (shadow_priority > shadow_entries.size()) begin
                  shadow_priority = shadow_entries.size();
               end
               shadow_entries.insert(shadow_priority, word);
               shadow_priority++;
            end
         end
         MODE_GET: begin
            if (shadow_entries.size() == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.read_was_priority = (shadow_priority > 0);
               r.read_payload      = shadow_entries[0];
               shadow_entries.delete(0);
               if (shadow_priority > 0) begin
                  shadow_priority--;
               end
            end
         end
         default: begin
         end
      endcase
      r.occupancy      = COUNT_W'(shadow_entries.size());
      r.priority_count = COUNT_W'(shadow_priority);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         shadow_entries.delete();
         shadow_priority = 0;
         shadow_limit    = LIMIT_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transaction with no request outstanding");
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_read_payload !== want.read_payload) begin
                  report_mismatch($sformatf("read_payload %h, expected %h",
                                            rsp_read_payload, want.read_payload));
               end
               if (rsp_read_was_priority !== want.read_was_priority) begin
                  report_mismatch($sformatf("read_was_priority %b, expected %b",
                                            rsp_read_was_priority, want.read_was_priority));
               end
               if (rsp_occupancy !== want.occupancy) begin
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_occupancy, want.occupancy));
               end
               if (rsp_priority_count !== want.priority_count) begin
                  report_mismatch($sformatf("priority_count %0d, expected %0d",
                                            rsp_priority_count, want.priority_count));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            shadow_limit = csr_queue_limit;
         end
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(),
                                    apply_queue_op(req_mode, req_payload));
         end
      end
      results_outstanding = expected_results.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tcpf_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int COUNT_W     = $clog2(DEF_MAX_DEPTH + 1);
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 250;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [MODE_W-1:0]           req_mode = MODE_PUT;
   logic [DEF_PAYLOAD_BITS-1:0] req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [DEF_PAYLOAD_BITS-1:0] rsp_read_payload;
   logic                        rsp_read_was_priority;
   logic [COUNT_W-1:0]          rsp_occupancy;
   logic [COUNT_W-1:0]          rsp_priority_count;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [LIMIT_W-1:0]          csr_queue_limit = LIMIT_RESET;

   int   mismatch_count;
   int   results_outstanding;
   int   cycle_count = 0;
   logic calm = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   two_class_priority_fifo_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_payload           (req_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_read_payload      (rsp_read_payload),
      .rsp_read_was_priority (rsp_read_was_priority),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_priority_count    (rsp_priority_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_queue_limit       (csr_queue_limit)
   );

   queue_result_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_payload           (req_payload),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_read_payload      (rsp_read_payload),
      .rsp_read_was_priority (rsp_read_was_priority),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_priority_count    (rsp_priority_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_queue_limit       (csr_queue_limit),
      .mismatch_count        (mismatch_count),
      .results_outstanding   (results_outstanding)
   );

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 20);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_op(input logic [MODE_W-1:0] op,
                          input logic [DEF_PAYLOAD_BITS-1:0] word);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= op;
      req_payload <= word;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_until_quiet();
      req_valid <= 1'b0;
      while (results_outstanding != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_until_quiet();
      csr_valid       <= 1'b1;
      csr_queue_limit <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [MODE_W-1:0]           op;
      logic [DEF_PAYLOAD_BITS-1:0] word;
      logic [LIMIT_W-1:0]          limit;
      int                          put_pct;
      int                          roll;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The reset limit of five is in force for the first sequence.
      send_op(MODE_GET, 32'h1357_9BDF);
      send_op(MODE_PRIO_PUT, 32'hFFFF_FFFF);
      send_op(MODE_PUT, 32'h0000_0000);
      send_op(MODE_PUT, 32'hA5A5_A5A5);
      send_op(MODE_PRIO_PUT, 32'h5A5A_5A5A);
      send_op(MODE_UNUSED, 32'h1234_5678);
      send_op(MODE_PUT, 32'h0000_FFFF);
      send_op(MODE_PUT, 32'hFFFF_0000);
      send_op(MODE_PRIO_PUT, 32'h8000_0001);
      repeat (6) send_op(MODE_GET, 32'hFFFF_FFFF);

      // A limit of zero behaves as a limit of one.
      write_limit(5'd0);
      send_op(MODE_PUT, 32'hDEAD_BEEF);
      send_op(MODE_PRIO_PUT, 32'hCAFE_F00D);
      send_op(MODE_GET, 32'h0);
      send_op(MODE_GET, 32'h0);
      send_op(MODE_UNUSED, 32'hFFFF_FFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: limit = 5'd16;
            1: limit = 5'd2;
            2: limit = 5'd31;
            3: limit = 5'd0;
            4: limit = 5'd1;
            default: limit = LIMIT_W'($urandom_range(0, 31));
         endcase
         case (phase)
            0: put_pct = 72;
            1: put_pct = 25;
            2: put_pct = 65;
            default: put_pct = $urandom_range(30, 70);
         endcase
         write_limit(limit);
         calm <= (phase == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               op = MODE_UNUSED;
            end else if (roll < 3 + put_pct) begin
               op = $urandom_range(0, 1) ? MODE_PRIO_PUT : MODE_PUT;
            end else begin
               op = MODE_GET;
            end
            case ($urandom_range(0, 9))
               0: word = '0;
               1: word = '1;
               default: word = $urandom;
            endcase
            send_op(op, word);
         end
         calm <= 1'b0;
      end

      wait_until_quiet();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
src/tcpf_pkg.sv
src/tcpf_store.sv
src/two_class_priority_fifo_unit.sv
tb/queue_result_checker.sv
tb/tb_top.sv
